/* rtl/cobsr_pkg.sv */
package cobsr_pkg;

	// default sizes
	localparam int BUFFER_DEPTH_DEF = 64;
	localparam int PACKET_BYTES_DEF = 4;

	// framing bytes
	localparam logic [7:0] FRAME_DELIM = 8'h00;
	localparam logic [7:0] CODE_MAX    = 8'hFF;

	// result status codes
	typedef logic [1:0] status_t;
	localparam status_t STATUS_NONE    = 2'd0;
	localparam status_t STATUS_OK      = 2'd1;
	localparam status_t STATUS_LEN_ERR = 2'd2;
	localparam status_t STATUS_SUM_ERR = 2'd3;

endpackage

/* rtl/cobsr_byte_if.sv */
interface cobsr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/cobsr_result_if.sv */
interface cobsr_result_if;
	logic                 valid;
	logic                 ready;
	cobsr_pkg::status_t   status;
	logic [7:0]           dev_id;
	logic [15:0]          range_value;

	modport source (output valid, output status, output dev_id, output range_value,
		input ready);
	modport sink (input valid, input status, input dev_id, input range_value,
		output ready);
endinterface

/* rtl/cobsr_packet_receiver.sv */
// cobsr_packet_receiver: byte-wise cobs/r deframer with an xor-checked sensor packet
//
// rx channel: one received byte per transfer; a zero byte closes the current frame.
// pkt channel: exactly one result per accepted byte. a nonzero byte gives status none;
//   a delimiter gives ok, length error or checksum error (none for an empty frame).
//   dev_id and range_value are nonzero only with status ok.
// latency: the result of a byte is offered in the cycle after its transfer.
// throughput: one byte per cycle unless the result stalls; decode, checksum and result
//   selection all sit between the frame state registers and the single result register.
// stall: the result register holds while pkt.ready is low; rx.ready then drops, so
//   a new byte is taken whenever the result register is empty or being drained.
// overlong frames (more than BUFFER_DEPTH nonzero bytes) are dropped silently and
//   the following bytes start a fresh frame.
// reset: arst_n clears the frame state and drops any result that was pending; the
//   stored packet bytes are not cleared, they are only read after a full rewrite.
module cobsr_packet_receiver #(
	parameter int BUFFER_DEPTH = cobsr_pkg::BUFFER_DEPTH_DEF,
	parameter int PACKET_BYTES = cobsr_pkg::PACKET_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cobsr_byte_if.sink            rx,
	cobsr_result_if.source        pkt
);

	localparam int RAW_W  = $clog2(BUFFER_DEPTH + 1);
	localparam int CNT_W  = $clog2(PACKET_BYTES + 2);
	// byte positions of the range field, zero when the packet has no such data byte
	localparam int LO_IDX = (PACKET_BYTES > 2) ? 1 : 0;
	localparam int HI_IDX = (PACKET_BYTES > 3) ? 2 : 0;

	// frame state
	logic [RAW_W-1:0] raw_count_q;
	logic [7:0]       run_left_q;
	logic [7:0]       last_code_q;
	logic             code_seen_q;
	logic [CNT_W-1:0] dec_count_q;
	logic [7:0]       pkt_bytes_q [PACKET_BYTES];

	// next frame state
	logic [RAW_W-1:0] raw_count_nx;
	logic [7:0]       run_left_nx;
	logic [7:0]       last_code_nx;
	logic             code_seen_nx;
	logic [CNT_W-1:0] dec_count_nx;
	logic [7:0]       pkt_bytes_nx [PACKET_BYTES];
	logic             clear_frame;
	logic             frame_end;

	// at most one decoded byte per input byte
	logic             dec_en;
	logic [7:0]       dec_val;

	// result of this byte
	logic [7:0]          chk_xor;
	cobsr_pkg::status_t  res_status;
	logic [7:0]          res_sid;
	logic [15:0]         res_range;

	// result register
	logic                pkt_valid_q;
	cobsr_pkg::status_t  status_q;
	logic [7:0]          dev_id_q;
	logic [15:0]         range_value_q;

	logic accept;

	assign rx.ready = !pkt_valid_q || pkt.ready;
	assign accept   = rx.valid && rx.ready;

	// run tracking: code bytes open a run, data bytes consume it
	always_comb begin
		raw_count_nx = raw_count_q;
		run_left_nx  = run_left_q;
		last_code_nx = last_code_q;
		code_seen_nx = code_seen_q;
		dec_en       = 1'b0;
		dec_val      = '0;
		clear_frame  = 1'b0;
		frame_end    = 1'b0;
		if (rx.rx_byte != cobsr_pkg::FRAME_DELIM) begin
			if (raw_count_q == RAW_W'(BUFFER_DEPTH)) begin
				clear_frame = 1'b1;
			end else begin
				raw_count_nx = raw_count_q + RAW_W'(1);
				if (run_left_q == 8'd0) begin
					// implicit zero between runs unless the previous code was the maximum
					dec_en       = code_seen_q && (last_code_q != cobsr_pkg::CODE_MAX);
					dec_val      = 8'd0;
					last_code_nx = rx.rx_byte;
					run_left_nx  = rx.rx_byte - 8'd1;
					code_seen_nx = 1'b1;
				end else begin
					dec_en      = 1'b1;
					dec_val     = rx.rx_byte;
					run_left_nx = run_left_q - 8'd1;
				end
			end
		end else if (raw_count_q != '0) begin
			// reduction rule: an unfinished run ends with its own code byte
			dec_en      = (run_left_q != 8'd0);
			dec_val     = last_code_q;
			frame_end   = 1'b1;
			clear_frame = 1'b1;
		end
	end

	// store the decoded byte, count saturates one above the packet length
	always_comb begin
		for (int i = 0; i < PACKET_BYTES; i++) begin
			pkt_bytes_nx[i] = (dec_en && dec_count_q == CNT_W'(i)) ? dec_val : pkt_bytes_q[i];
		end
		dec_count_nx = dec_count_q;
		if (dec_en) begin
			if (dec_count_q < CNT_W'(PACKET_BYTES)) begin
				dec_count_nx = dec_count_q + CNT_W'(1);
			end else begin
				dec_count_nx = CNT_W'(PACKET_BYTES + 1);
			end
		end
	end

	// frame check on the bytes including the one decoded at the delimiter
	always_comb begin
		chk_xor = '0;
		for (int i = 0; i < PACKET_BYTES - 1; i++) begin
			chk_xor = chk_xor ^ pkt_bytes_nx[i];
		end
		res_status = cobsr_pkg::STATUS_NONE;
		res_sid    = '0;
		res_range  = '0;
		if (frame_end) begin
			if (dec_count_nx != CNT_W'(PACKET_BYTES)) begin
				res_status = cobsr_pkg::STATUS_LEN_ERR;
			end else if (chk_xor != pkt_bytes_nx[PACKET_BYTES-1]) begin
				res_status = cobsr_pkg::STATUS_SUM_ERR;
			end else begin
				res_status = cobsr_pkg::STATUS_OK;
				res_sid    = pkt_bytes_nx[0];
				res_range  = {(PACKET_BYTES > 3) ? pkt_bytes_nx[HI_IDX] : 8'd0,
					(PACKET_BYTES > 2) ? pkt_bytes_nx[LO_IDX] : 8'd0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_count_q <= '0;
			run_left_q  <= '0;
			last_code_q <= '0;
			code_seen_q <= 1'b0;
			dec_count_q <= '0;
		end else if (accept) begin
			if (clear_frame) begin
				raw_count_q <= '0;
				run_left_q  <= '0;
				last_code_q <= '0;
				code_seen_q <= 1'b0;
				dec_count_q <= '0;
			end else begin
				raw_count_q <= raw_count_nx;
				run_left_q  <= run_left_nx;
				last_code_q <= last_code_nx;
				code_seen_q <= code_seen_nx;
				dec_count_q <= dec_count_nx;
			end
		end
	end

	// packet bytes carry no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < PACKET_BYTES; i++) begin
				pkt_bytes_q[i] <= pkt_bytes_nx[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_q <= 1'b0;
		end else if (accept) begin
			pkt_valid_q <= 1'b1;
		end else if (pkt.ready) begin
			pkt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= res_status;
			dev_id_q      <= res_sid;
			range_value_q <= res_range;
		end
	end

	assign pkt.valid       = pkt_valid_q;
	assign pkt.status      = status_q;
	assign pkt.dev_id      = dev_id_q;
	assign pkt.range_value = range_value_q;

`ifndef SYNTH
	a_raw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		raw_count_q <= RAW_W'(BUFFER_DEPTH))
		else $error("raw byte count past buffer depth");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dec_count_q <= CNT_W'(PACKET_BYTES + 1))
		else $error("decoded count past saturation");

	a_run_needs_code: assert property (@(posedge clk) disable iff (!arst_n)
		!code_seen_q |-> (run_left_q == 8'd0 && dec_count_q == '0))
		else $error("run or decoded bytes without a code byte");

	a_data_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt_valid_q && status_q != cobsr_pkg::STATUS_OK) |->
		(dev_id_q == 8'd0 && range_value_q == 16'd0))
		else $error("packet data without status ok");

	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rx.rx_byte == cobsr_pkg::FRAME_DELIM && raw_count_q == '0) |=>
		(pkt_valid_q && status_q == cobsr_pkg::STATUS_NONE))
		else $error("empty frame gave a packet status");
`endif

endmodule

/* verif/cobsr_packet_receiver_tb.sv */
module cobsr_packet_receiver_tb;

	localparam int BUF_DEPTH   = cobsr_pkg::BUFFER_DEPTH_DEF;
	localparam int PKT_LEN     = cobsr_pkg::PACKET_BYTES_DEF;
	localparam int HOLD_CYCLES = 48;
	localparam int RAND_ITEMS  = 400;

	typedef struct packed {
		cobsr_pkg::status_t status;
		logic [7:0]         dev_id;
		logic [15:0]        range_value;
	} pkt_result_t;

	// one row of the directed table: a byte sent reps times in a row;
	// typed rows carry a hand-written expectation for their last transfer
	typedef struct packed {
		logic [7:0]  data;
		int          reps;
		logic        typed;
		pkt_result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	cobsr_byte_if   rx_if ();
	cobsr_result_if pkt_if ();

	cobsr_packet_receiver #(
		.BUFFER_DEPTH(BUF_DEPTH),
		.PACKET_BYTES(PKT_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if.sink),
		.pkt(pkt_if.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// expected results the block still owes us, one per byte, oldest first
	pkt_result_t awaited_pkts[$];
	int          mismatches = 0;
	logic [7:0]  frame_bytes[$];
	bit          src_gaps = 1'b1;

	// deframer state mirror
	int          frame_raw_len;
	int          run_remaining;
	logic [7:0]  open_code;
	bit          code_open;
	int          dec_len;
	logic [7:0]  dec_bytes [PKT_LEN];

	stim_row_t directed_rows [24] = '{
		'{8'h00, 1, 1'b1, '{cobsr_pkg::STATUS_NONE, 8'h00, 16'h0000}},	// empty frame after reset
		'{8'h05, 1, 1'b0, '0},
		'{8'hFF, 4, 1'b0, '0},
		'{8'h00, 1, 1'b1, '{cobsr_pkg::STATUS_OK, 8'hFF, 16'hFFFF}},		// all-ones packet
		'{8'h01, 5, 1'b0, '0},
		'{8'h00, 1, 1'b1, '{cobsr_pkg::STATUS_OK, 8'h00, 16'h0000}},		// implicit zeros only
		'{8'h70, 1, 1'b0, '0},
		'{8'h01, 1, 1'b0, '0},
		'{8'h02, 1, 1'b0, '0},
		'{8'h03, 1, 1'b0, '0},
		'{8'h00, 1, 1'b1, '{cobsr_pkg::STATUS_SUM_ERR, 8'h00, 16'h0000}},	// reduced, bad xor
		'{8'h70, 1, 1'b0, '0},
		'{8'h01, 1, 1'b0, '0},
		'{8'h02, 1, 1'b0, '0},
		'{8'h03, 1, 1'b0, '0},
		'{8'h04, 1, 1'b0, '0},
		'{8'h00, 1, 1'b1, '{cobsr_pkg::STATUS_LEN_ERR, 8'h00, 16'h0000}},	// five decoded bytes
		'{8'hFF, 65, 1'b0, '0},
		'{8'h00, 1, 1'b1, '{cobsr_pkg::STATUS_NONE, 8'h00, 16'h0000}},	// overlong frame dropped
		'{8'h70, 1, 1'b0, '0},
		'{8'h12, 1, 1'b0, '0},
		'{8'h34, 1, 1'b0, '0},
		'{8'h56, 1, 1'b0, '0},
		'{8'h00, 1, 1'b0, '0}									// reduced good packet
	};

	function automatic void restart_frame();
		frame_raw_len = 0;
		run_remaining = 0;
		open_code     = 8'h00;
		code_open     = 1'b0;
		dec_len       = 0;
	endfunction

	// bytes past the packet length are only counted, and the count saturates
	function automatic void push_decoded(input logic [7:0] b);
		if (dec_len < PKT_LEN) begin
			dec_bytes[dec_len] = b;
			dec_len++;
		end else begin
			dec_len = PKT_LEN + 1;
		end
	endfunction

	// expected result of one received byte; advances the mirrored frame state
	function automatic pkt_result_t deframe_byte(input logic [7:0] b);
		pkt_result_t r;
		logic [7:0]  xsum;
		r = '0;
		if (b != cobsr_pkg::FRAME_DELIM) begin
			frame_raw_len++;
			if (frame_raw_len > BUF_DEPTH) begin
				restart_frame();
			end else if (run_remaining == 0) begin
				// a finished short run hides a zero
				if (code_open && open_code != cobsr_pkg::CODE_MAX)
					push_decoded(8'h00);
				open_code     = b;
				run_remaining = int'(b) - 1;
				code_open     = 1'b1;
			end else begin
				push_decoded(b);
				run_remaining--;
			end
		end else if (frame_raw_len != 0) begin
			// unfinished run: the code byte itself is the last byte
			if (run_remaining != 0)
				push_decoded(open_code);
			if (dec_len != PKT_LEN) begin
				r.status = cobsr_pkg::STATUS_LEN_ERR;
			end else begin
				xsum = 8'h00;
				for (int i = 0; i < PKT_LEN - 1; i++)
					xsum ^= dec_bytes[i];
				if (xsum != dec_bytes[PKT_LEN-1]) begin
					r.status = cobsr_pkg::STATUS_SUM_ERR;
				end else begin
					r.status      = cobsr_pkg::STATUS_OK;
					r.dev_id      = dec_bytes[0];
					r.range_value = {dec_bytes[2], dec_bytes[1]};
				end
			end
			restart_frame();
		end
		return r;
	endfunction

	// stuff a payload into frame_bytes, with the reduced final code when asked
	function automatic void cobs_pack(input logic [7:0] payload[$], input bit reduce);
		logic [7:0] run_bytes[$];
		foreach (payload[p]) begin
			if (payload[p] == 8'h00) begin
				frame_bytes = {frame_bytes, 8'(run_bytes.size() + 1)};
				frame_bytes = {frame_bytes, run_bytes};
				run_bytes.delete();
			end else begin
				run_bytes = {run_bytes, payload[p]};
			end
		end
		if (reduce && run_bytes.size() > 0 && int'(run_bytes[$]) > run_bytes.size()) begin
			frame_bytes = {frame_bytes, run_bytes[$]};
			for (int j = 0; j < run_bytes.size() - 1; j++)
				frame_bytes = {frame_bytes, run_bytes[j]};
		end else begin
			frame_bytes = {frame_bytes, 8'(run_bytes.size() + 1)};
			frame_bytes = {frame_bytes, run_bytes};
		end
		frame_bytes = {frame_bytes, cobsr_pkg::FRAME_DELIM};
	endfunction

	function automatic logic [7:0] some_byte();
		return ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom_range(255));
	endfunction

	// offer one byte, idling first at random, and log its expectation on transfer
	task automatic send_byte(input logic [7:0] b, input bit typed, input pkt_result_t want);
		pkt_result_t predicted;
		while (src_gaps && $urandom_range(99) < 37) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		predicted = deframe_byte(b);
		awaited_pkts = {awaited_pkts, typed ? want : predicted};
	endtask

	// byte source
	initial begin
		logic [7:0] payload[$];
		int         rand_sent;
		int         frame_no;
		int         kind;
		int         n;
		bit         drained;
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = 8'h00;
		drained       = 1'b0;
		restart_frame();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r])
			for (int k = 0; k < directed_rows[r].reps; k++)
				send_byte(directed_rows[r].data,
					directed_rows[r].typed && k == directed_rows[r].reps - 1,
					directed_rows[r].want);

		rand_sent = 0;
		frame_no  = 0;
		while (rand_sent < RAND_ITEMS) begin
			// a stretch with no source gaps in the middle
			src_gaps = !(rand_sent >= 150 && rand_sent < 260);
			// once, let the pipe drain completely before the next frame
			if (!drained && rand_sent >= 300) begin
				drained = 1'b1;
				rx_if.valid <= 1'b0;
				do @(posedge clk); while (awaited_pkts.size() != 0);
			end
			payload.delete();
			frame_bytes.delete();
			kind = $urandom_range(99);
			if (kind < 70) begin
				// well-formed packet, mostly with a good checksum
				for (int k = 0; k < PKT_LEN - 1; k++)
					payload = {payload, some_byte()};
				payload = {payload, ($urandom_range(6) == 0) ? 8'($urandom_range(255)) :
					payload[0] ^ payload[1] ^ payload[2]};
				cobs_pack(payload, 1'($urandom_range(1)));
			end else if (kind < 80) begin
				// wrong decoded length, empty payload included
				n = $urandom_range(PKT_LEN + 2);
				if (n >= PKT_LEN)
					n++;
				for (int k = 0; k < n; k++)
					payload = {payload, some_byte()};
				cobs_pack(payload, 1'($urandom_range(1)));
			end else if (kind < 94) begin
				// raw noise, zeros anywhere
				n = $urandom_range(1, 10);
				for (int k = 0; k < n; k++)
					frame_bytes = {frame_bytes, 8'($urandom_range(255))};
				frame_bytes = {frame_bytes, cobsr_pkg::FRAME_DELIM};
			end else begin
				// around the buffer limit
				n = $urandom_range(BUF_DEPTH - 4, BUF_DEPTH + 6);
				for (int k = 0; k < n; k++)
					frame_bytes = {frame_bytes, 8'($urandom_range(1, 255))};
				frame_bytes = {frame_bytes, cobsr_pkg::FRAME_DELIM};
			end
			rand_sent += frame_bytes.size();
			while (frame_bytes.size() != 0)
				send_byte(frame_bytes.pop_front(), 1'b0, '0);
			frame_no++;
		end

		rx_if.valid <= 1'b0;
		do @(posedge clk); while (awaited_pkts.size() != 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("** cobsr_packet_receiver: PASSED **");
		else
			$display("** cobsr_packet_receiver: FAILED **");
		$finish;
	end

	// result sink: random stalls, a calm stretch, and two long hold-offs
	initial begin
		int taken;
		int next_hold;
		taken          = 0;
		next_hold      = 120;
		pkt_if.ready   = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pkt_if.valid && pkt_if.ready)
				taken++;
			if (taken >= next_hold) begin
				// source keeps offering, so the block fills and stops taking bytes
				pkt_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				next_hold += 330;
			end else begin
				pkt_if.ready <= (taken >= 200 && taken < 320) || $urandom_range(99) >= 37;
			end
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		pkt_result_t want;
		if (arst_n && pkt_if.valid && pkt_if.ready) begin
			if (awaited_pkts.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, status %0d dev_id %02h range_value %04h",
					$time, pkt_if.status, pkt_if.dev_id, pkt_if.range_value);
			end else begin
				want = awaited_pkts.pop_front();
				if (pkt_if.status !== want.status) begin
					mismatches++;
					$display("%0t: status expected %0d, got %0d",
						$time, want.status, pkt_if.status);
				end
				if (pkt_if.dev_id !== want.dev_id) begin
					mismatches++;
					$display("%0t: dev_id expected %02h, got %02h",
						$time, want.dev_id, pkt_if.dev_id);
				end
				if (pkt_if.range_value !== want.range_value) begin
					mismatches++;
					$display("%0t: range_value expected %04h, got %04h",
						$time, want.range_value, pkt_if.range_value);
				end
			end
		end
	end

	initial begin
		#400000;
		$display("** cobsr_packet_receiver: FAILED **");
		$finish;
	end

endmodule
